// File: rtl/sst_pkg.sv
package sst_pkg;

  localparam int MAX_IDS_DEF  = 256;
  localparam int SIG_BITS_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int ID_IO_W  = 8;
  localparam int SIG_IO_W = 32;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 9;

  localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DESTROY = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_GET     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_IO_W-1:0]  ent;
    logic [SIG_IO_W-1:0] sig;
    logic [LIVE_W-1:0]   live;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

// File: rtl/sst_free_fifo.sv
module sst_free_fifo #(
  parameter int MAX_IDS = sst_pkg::MAX_IDS_DEF,
  parameter int ID_W    = $clog2(MAX_IDS),
  parameter int CNT_W   = $clog2(MAX_IDS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  sst_pkg::fifo_ctrl_t ctrl,
  input  logic [ID_W-1:0]    push_id,
  output logic [ID_W-1:0]    rdata,
  output logic               empty
);
  import sst_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);
  localparam logic [CNT_W:0]   MAX_SUM = (CNT_W + 1)'(MAX_IDS);

  logic [ID_W-1:0] q_mem [MAX_IDS];
  logic [ID_W-1:0] head;
  logic [CNT_W-1:0] used;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic [CNT_W-1:0] head_inc;
  logic [ID_W-1:0]  head_next;
  logic             push_ok;
  logic             pop_ok;

  assign empty   = (used == '0);
  assign push_ok = ctrl.push && (used != MAX_CNT);
  assign pop_ok  = ctrl.pop && !empty;

  always_comb begin
    tail_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(used);
    tail_wrap = (tail_sum >= MAX_SUM) ? tail_sum - MAX_SUM : tail_sum;
    head_inc  = CNT_W'(head) + 1'b1;
    head_next = (head_inc == MAX_CNT) ? '0 : head_inc[ID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[tail_wrap[ID_W-1:0]] <= push_id;
    end
    if (pop_ok) begin
      rdata <= q_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      used <= '0;
    end else begin
      if (pop_ok) begin
        head <= head_next;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

endmodule

// File: rtl/sst_engine.sv
module sst_engine #(
  parameter int MAX_IDS        = sst_pkg::MAX_IDS_DEF,
  parameter int SIGNATURE_BITS = sst_pkg::SIG_BITS_DEF,
  parameter int ID_W           = $clog2(MAX_IDS),
  parameter int CNT_W          = $clog2(MAX_IDS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sst_pkg::OPCODE_W-1:0]   in_op,
  input  logic [sst_pkg::ID_IO_W-1:0]    in_id,
  input  logic [sst_pkg::SIG_IO_W-1:0]   in_sig,
  output logic                           res_valid,
  input  logic                           res_ready,
  output sst_pkg::result_t               res,
  output sst_pkg::fifo_ctrl_t            fifo_ctrl,
  output logic [ID_W-1:0]                fifo_push_id,
  input  logic [ID_W-1:0]                fifo_rdata,
  input  logic                           fifo_empty
);
  import sst_pkg::*;

  localparam int SW  = SIGNATURE_BITS;
  localparam int SPW = ID_W + 1;
  localparam int DNW = ID_W + SW;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_POP_WAIT, S_PUT_RD, S_PUT_DEC,
    S_SP_RD, S_SP_DEC, S_DN_DEC, S_RM_FIN, S_CLR, S_CLR_LAST, S_DONE
  } state_t;

  function automatic logic [ID_IO_W-1:0] to_ent(logic [ID_W-1:0] v);
    logic [31:0] w;
    w = {{(32 - ID_W){1'b0}}, v};
    return w[ID_IO_W-1:0];
  endfunction

  state_t state;

  // sparse entry: {present, dense slot}; dense entry: {id, signature}
  logic [SPW-1:0] sp_mem [MAX_IDS];
  logic [DNW-1:0] dn_mem [MAX_IDS];
  logic [SPW-1:0] sp_rdata;
  logic [DNW-1:0] dn_rdata;

  logic            sp_we, sp_re, dn_we, dn_re;
  logic [ID_W-1:0] sp_waddr, sp_raddr, dn_waddr, dn_raddr;
  logic [SPW-1:0]  sp_wdata;
  logic [DNW-1:0]  dn_wdata;

  logic [CNT_W-1:0]    init_idx;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    fresh;
  logic [CNT_W-1:0]    clr_idx;
  logic                clr_pend;
  logic [OPCODE_W-1:0] op;
  logic                id_ok;
  logic [ID_W-1:0]     cur_id;
  logic [SW-1:0]       sig_w;
  logic [ID_W-1:0]     slot;
  logic [STATUS_W-1:0] res_status;
  logic [ID_IO_W-1:0]  res_ent;
  logic [SW-1:0]       res_sig;

  logic [CNT_W-1:0] cnt_m1;
  logic [31:0]      id_ext;
  logic [63:0]      sig_ext;
  logic [63:0]      sig_out_ext;
  logic [31:0]      cnt_ext;

  assign cnt_m1  = count - 1'b1;
  assign id_ext  = {24'd0, in_id};
  assign sig_ext = {32'd0, in_sig};
  assign cnt_ext = {{(32 - CNT_W){1'b0}}, count};

  always_comb begin
    sig_out_ext = '0;
    sig_out_ext[SW-1:0] = res_sig;
  end

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.status = res_status;
  assign res.ent    = res_ent;
  assign res.sig    = sig_out_ext[SIG_IO_W-1:0];
  assign res.live   = cnt_ext[LIVE_W-1:0];

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[sp_waddr] <= sp_wdata;
    end
    if (sp_re) begin
      sp_rdata <= sp_mem[sp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dn_we) begin
      dn_mem[dn_waddr] <= dn_wdata;
    end
    if (dn_re) begin
      dn_rdata <= dn_mem[dn_raddr];
    end
  end

  // Memory accesses of one transaction are spaced by the sequencer, so a read
  // never meets a write to the same entry in the same cycle.
  always_comb begin
    sp_we          = 1'b0;
    sp_re          = 1'b0;
    dn_we          = 1'b0;
    dn_re          = 1'b0;
    sp_waddr       = cur_id;
    sp_raddr       = cur_id;
    dn_waddr       = slot;
    dn_raddr       = slot;
    sp_wdata       = '0;
    dn_wdata       = {cur_id, sig_w};
    fifo_ctrl.push = 1'b0;
    fifo_ctrl.pop  = 1'b0;
    fifo_push_id   = cur_id;
    unique case (state)
      S_INIT: begin
        sp_we    = 1'b1;
        sp_waddr = init_idx[ID_W-1:0];
      end
      S_DISPATCH: begin
        fifo_ctrl.pop = (op == OP_CREATE) && (fresh == MAX_CNT) && !fifo_empty;
      end
      S_PUT_RD, S_SP_RD: begin
        sp_re = 1'b1;
      end
      S_PUT_DEC: begin
        if (sp_rdata[ID_W]) begin
          dn_we    = 1'b1;
          dn_waddr = sp_rdata[ID_W-1:0];
        end else if (count != MAX_CNT) begin
          sp_we    = 1'b1;
          sp_wdata = {1'b1, count[ID_W-1:0]};
          dn_we    = 1'b1;
          dn_waddr = count[ID_W-1:0];
        end
      end
      S_SP_DEC: begin
        dn_re    = sp_rdata[ID_W];
        dn_raddr = (op == OP_GET) ? sp_rdata[ID_W-1:0] : cnt_m1[ID_W-1:0];
      end
      S_DN_DEC: begin
        if (op == OP_DESTROY) begin
          sp_we          = 1'b1;
          sp_waddr       = dn_rdata[DNW-1:SW];
          sp_wdata       = {1'b1, slot};
          dn_we          = 1'b1;
          dn_wdata       = dn_rdata;
          fifo_ctrl.push = 1'b1;
        end
      end
      S_RM_FIN: begin
        sp_we = 1'b1;
      end
      S_CLR: begin
        dn_re    = 1'b1;
        dn_raddr = clr_idx[ID_W-1:0];
        sp_we    = clr_pend;
        sp_waddr = dn_rdata[DNW-1:SW];
      end
      S_CLR_LAST: begin
        sp_we    = 1'b1;
        sp_waddr = dn_rdata[DNW-1:SW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_idx <= '0;
      count    <= '0;
      fresh    <= '0;
      clr_pend <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (init_idx == MAX_CNT - 1'b1) begin
            state <= S_IDLE;
          end else begin
            init_idx <= init_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op         <= in_op;
            id_ok      <= (id_ext < MAX_IDS);
            cur_id     <= id_ext[ID_W-1:0];
            sig_w      <= sig_ext[SW-1:0];
            res_status <= ST_OK;
            res_ent    <= in_id;
            res_sig    <= '0;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (op)
            OP_CREATE: begin
              sig_w <= '0;
              if (fresh != MAX_CNT) begin
                cur_id  <= fresh[ID_W-1:0];
                res_ent <= to_ent(fresh[ID_W-1:0]);
                fresh   <= fresh + 1'b1;
                state   <= S_PUT_RD;
              end else if (!fifo_empty) begin
                state <= S_POP_WAIT;
              end else begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end
            end
            OP_DESTROY, OP_GET: begin
              if (id_ok) begin
                state <= S_SP_RD;
              end else begin
                res_status <= ST_ABSENT;
                state      <= S_DONE;
              end
            end
            OP_SET: begin
              if (id_ok) begin
                state <= S_PUT_RD;
              end else begin
                res_status <= ST_ABSENT;
                state      <= S_DONE;
              end
            end
            OP_CLEAR: begin
              clr_idx  <= '0;
              clr_pend <= 1'b0;
              state    <= (count == '0) ? S_DONE : S_CLR;
            end
            default: state <= S_DONE;
          endcase
        end
        S_POP_WAIT: begin
          cur_id  <= fifo_rdata;
          res_ent <= to_ent(fifo_rdata);
          state   <= S_PUT_RD;
        end
        S_PUT_RD: state <= S_PUT_DEC;
        S_PUT_DEC: begin
          if (!sp_rdata[ID_W] && (count != MAX_CNT)) begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_SP_RD: state <= S_SP_DEC;
        S_SP_DEC: begin
          slot <= sp_rdata[ID_W-1:0];
          if (!sp_rdata[ID_W] || ((op == OP_DESTROY) && (count == '0))) begin
            res_status <= ST_ABSENT;
            state      <= S_DONE;
          end else begin
            state <= S_DN_DEC;
          end
        end
        S_DN_DEC: begin
          if (op == OP_GET) begin
            res_sig <= dn_rdata[SW-1:0];
            state   <= S_DONE;
          end else begin
            count <= cnt_m1;
            state <= S_RM_FIN;
          end
        end
        S_RM_FIN: state <= S_DONE;
        S_CLR: begin
          clr_pend <= 1'b1;
          if (clr_idx == cnt_m1) begin
            state <= S_CLR_LAST;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_CLR_LAST: begin
          count <= '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/sparse_set_id_table_top.sv
// Path from input transaction to m_axis_tvalid: unused opcodes, ids out of range, create
// with no id left and clear of an empty table go straight to done; set and fresh create
// read, then write the sparse entry; get or destroy of an absent id only reads it; create
// from the free queue first takes the popped id; get also reads the dense entry; destroy
// also moves the last entry in; clear visits each live entry. One item at a time. Reset:
// synchronous; a sweep then marks every id absent, with s_axis_tready low until it ends.
module sparse_set_id_table_top #(
  parameter int MAX_IDS        = sst_pkg::MAX_IDS_DEF,
  parameter int SIGNATURE_BITS = sst_pkg::SIG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // entity_id[7:0], signature_in[39:8]
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // entity_out[7:0], signature_out[39:8],
                                     // live_count[48:40], zero[55:49]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import sst_pkg::*;

  localparam int ID_W  = $clog2(MAX_IDS);
  localparam int CNT_W = $clog2(MAX_IDS + 1);

  fifo_ctrl_t      fifo_ctrl;
  logic [ID_W-1:0] fifo_push_id;
  logic [ID_W-1:0] fifo_rdata;
  logic            fifo_empty;
  logic            res_valid;
  logic            res_ready;
  result_t         res;

  sst_free_fifo #(
    .MAX_IDS (MAX_IDS),
    .ID_W    (ID_W),
    .CNT_W   (CNT_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fifo_ctrl),
    .push_id (fifo_push_id),
    .rdata   (fifo_rdata),
    .empty   (fifo_empty)
  );

  sst_engine #(
    .MAX_IDS        (MAX_IDS),
    .SIGNATURE_BITS (SIGNATURE_BITS),
    .ID_W           (ID_W),
    .CNT_W          (CNT_W)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_op        (s_axis_tuser),
    .in_id        (s_axis_tdata[7:0]),
    .in_sig       (s_axis_tdata[39:8]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .fifo_ctrl    (fifo_ctrl),
    .fifo_push_id (fifo_push_id),
    .fifo_rdata   (fifo_rdata),
    .fifo_empty   (fifo_empty)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {7'd0, res.live, res.sig, res.ent};
      m_axis_tuser <= res.status;
    end
  end

`ifndef SYNTHESIS
  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready right after reset");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && res_valid))
    else $error("result offered while accepting input");

  a_fail_has_zero_sig: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[39:8] == 32'd0))
    else $error("nonzero signature on failed transaction");
`endif

endmodule

// File: bench/sparse_set_id_table_top_tb.sv
`timescale 1ns / 1ps

module sparse_set_id_table_top_tb;
  import sst_pkg::*;

  localparam int NUM_IDS     = MAX_IDS_DEF;
  localparam int PHASE_LEN   = 650;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 300;

  // opcodes the block does not decode
  localparam logic [OPCODE_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [ID_IO_W-1:0]  id;
    logic [SIG_IO_W-1:0] sig;
    bit                  typed;
    result_t             res;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // entity_id[7:0], signature_in[39:8]
  logic [2:0]  s_axis_tuser = '0;  // opcode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // entity_out[7:0], signature_out[39:8], live_count[48:40]
  logic [1:0]  m_axis_tuser;       // status[1:0]

  sparse_set_id_table_top uut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // directed transactions; typed results only where obvious
  step_row_t dir_rows [23] = '{
    '{OP_GET,     8'd0,   32'd0,        1'b1, {ST_ABSENT, 8'd0,   32'd0,        9'd0}},
    '{OP_DESTROY, 8'd255, 32'd0,        1'b1, {ST_ABSENT, 8'd255, 32'd0,        9'd0}},
    '{OP_SPARE5,  8'h5A,  32'hFFFFFFFF, 1'b1, {ST_OK,     8'h5A,  32'd0,        9'd0}},
    '{OP_SPARE6,  8'hA5,  32'h12345678, 1'b1, {ST_OK,     8'hA5,  32'd0,        9'd0}},
    '{OP_SPARE7,  8'hFF,  32'd0,        1'b1, {ST_OK,     8'hFF,  32'd0,        9'd0}},
    '{OP_SET,     8'd255, 32'hFFFFFFFF, 1'b1, {ST_OK,     8'd255, 32'd0,        9'd1}},
    '{OP_GET,     8'd255, 32'd0,        1'b1, {ST_OK,     8'd255, 32'hFFFFFFFF, 9'd1}},
    '{OP_CREATE,  8'h77,  32'hFFFFFFFF, 1'b1, {ST_OK,     8'd0,   32'd0,        9'd2}},
    '{OP_CREATE,  8'd0,   32'd0,        1'b1, {ST_OK,     8'd1,   32'd0,        9'd3}},
    '{OP_GET,     8'd0,   32'd0,        1'b1, {ST_OK,     8'd0,   32'd0,        9'd3}},
    '{OP_SET,     8'd0,   32'hA5A5A5A5, 1'b0, '0},
    '{OP_SET,     8'd0,   32'h5A5A5A5A, 1'b0, '0},
    '{OP_GET,     8'd0,   32'd0,        1'b0, '0},
    '{OP_DESTROY, 8'd255, 32'd0,        1'b1, {ST_OK,     8'd255, 32'd0,        9'd2}},
    '{OP_GET,     8'd255, 32'd0,        1'b1, {ST_ABSENT, 8'd255, 32'd0,        9'd2}},
    '{OP_DESTROY, 8'd255, 32'd0,        1'b1, {ST_ABSENT, 8'd255, 32'd0,        9'd2}},
    '{OP_GET,     8'd1,   32'd0,        1'b0, '0},
    '{OP_SET,     8'd255, 32'd0,        1'b0, '0},
    '{OP_DESTROY, 8'd255, 32'd0,        1'b0, '0},
    '{OP_CLEAR,   8'd0,   32'd0,        1'b1, {ST_OK,     8'd0,   32'd0,        9'd0}},
    '{OP_GET,     8'd1,   32'd0,        1'b1, {ST_ABSENT, 8'd1,   32'd0,        9'd0}},
    '{OP_CREATE,  8'd0,   32'd0,        1'b1, {ST_OK,     8'd2,   32'd0,        9'd1}},
    '{OP_CLEAR,   8'hFF,  32'hFFFFFFFF, 1'b1, {ST_OK,     8'hFF,  32'd0,        9'd0}}
  };

  // cumulative opcode mix per phase: create, destroy, set, get, clear; rest spare
  int mix [3][5] = '{'{40, 58, 78, 94, 96}, '{0, 50, 96, 100, 100}, '{60, 72, 82, 94, 97}};

  // predicted table state
  bit                  id_present [NUM_IDS];
  logic [ID_IO_W-1:0]  id_slot    [NUM_IDS];
  logic [ID_IO_W-1:0]  slot_id    [NUM_IDS];
  logic [SIG_IO_W-1:0] slot_sig   [NUM_IDS];
  logic [ID_IO_W-1:0]  reuse_fifo [NUM_IDS];
  logic [LIVE_W-1:0]   live_cnt   = '0;
  logic [LIVE_W-1:0]   fresh_id   = '0;
  logic [ID_IO_W-1:0]  reuse_head = '0;
  logic [LIVE_W-1:0]   reuse_used = '0;

  result_t pending_results [$];
  result_t want;
  bit      steady = 1'b0;
  int      items_sent, results_seen, mismatches, cycle_count;
  int      n_full, n_absent, n_reused, ids_dropped;

  function automatic void put_sig(logic [ID_IO_W-1:0] id, logic [SIG_IO_W-1:0] sig);
    if (id_present[id]) begin
      slot_sig[id_slot[id]] = sig;
    end else if (live_cnt < NUM_IDS) begin
      id_present[id]            = 1'b1;
      id_slot[id]               = live_cnt[ID_IO_W-1:0];
      slot_id[live_cnt[ID_IO_W-1:0]]  = id;
      slot_sig[live_cnt[ID_IO_W-1:0]] = sig;
      live_cnt++;
    end
  endfunction

  // swap-remove, then queue the id for reuse unless the queue is full
  function automatic void drop_id(logic [ID_IO_W-1:0] id);
    logic [ID_IO_W-1:0] hole, tail, moved;
    hole  = id_slot[id];
    tail  = 8'(live_cnt - 9'd1);
    moved = slot_id[tail];
    id_slot[moved]  = hole;
    id_present[id]  = 1'b0;
    slot_id[hole]   = slot_id[tail];
    slot_sig[hole]  = slot_sig[tail];
    live_cnt--;
    if (reuse_used < NUM_IDS) begin
      reuse_fifo[8'(reuse_head + reuse_used)] = id;
      reuse_used++;
    end else begin
      ids_dropped++;
    end
  endfunction

  function automatic result_t apply_id_op(logic [OPCODE_W-1:0] op, logic [ID_IO_W-1:0] id,
                                          logic [SIG_IO_W-1:0] sig);
    result_t r;
    r.status = ST_OK;
    r.ent    = id;
    r.sig    = '0;
    case (op)
      OP_CREATE: begin
        if (fresh_id < NUM_IDS) begin
          r.ent = fresh_id[ID_IO_W-1:0];
          fresh_id++;
          put_sig(r.ent, '0);
        end else if (reuse_used != 0) begin
          r.ent = reuse_fifo[reuse_head];
          reuse_head++;
          reuse_used--;
          n_reused++;
          put_sig(r.ent, '0);
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (id_present[id] && live_cnt != 0) drop_id(id);
        else r.status = ST_ABSENT;
      end
      OP_SET: put_sig(id, sig);
      OP_GET: begin
        if (id_present[id]) r.sig = slot_sig[id_slot[id]];
        else r.status = ST_ABSENT;
      end
      OP_CLEAR: begin
        for (int i = 0; i < live_cnt; i++) id_present[slot_id[i]] = 1'b0;
        live_cnt = '0;
      end
      default: ;
    endcase
    r.live = live_cnt;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_ABSENT) n_absent++;
    return r;
  endfunction

  function automatic logic [ID_IO_W-1:0] pick_live_id();
    if (live_cnt == 0) return 8'($urandom);
    return slot_id[$urandom_range(0, live_cnt - 1)];
  endfunction

  task automatic push_item(logic [OPCODE_W-1:0] op, logic [ID_IO_W-1:0] id,
                           logic [SIG_IO_W-1:0] sig, bit typed, result_t typed_res);
    result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {sig, id};
    do @(posedge clk); while (!s_axis_tready);
    res = apply_id_op(op, id, sig);
    pending_results = {pending_results, (typed ? typed_res : res)};
    items_sent++;
    if (!steady && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    logic [OPCODE_W-1:0] op;
    logic [ID_IO_W-1:0]  id;
    logic [SIG_IO_W-1:0] sig;
    int                  pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      push_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].sig, dir_rows[i].typed,
                dir_rows[i].res);
    // fill and reuse, then churn without create to overflow the free queue,
    // then drain it until no id is left
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < PHASE_LEN; n++) begin
        steady = (phase == 1 && n < 300);
        pick   = $urandom_range(0, 99);
        id     = 8'($urandom);
        sig    = $urandom;
        if (pick < mix[phase][0]) begin
          op = OP_CREATE;
        end else if (pick < mix[phase][1]) begin
          op = OP_DESTROY;
          if ($urandom_range(0, 99) < 85) id = pick_live_id();
        end else if (pick < mix[phase][2]) begin
          op = OP_SET;
        end else if (pick < mix[phase][3]) begin
          op = OP_GET;
          if ($urandom_range(0, 99) < 75) id = pick_live_id();
        end else if (pick < mix[phase][4]) begin
          op = OP_CLEAR;
        end else begin
          op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
        end
        push_item(op, id, sig, 1'b0, '0);
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d transactions, %0d checked, %0d ids reused, %0d dropped on a full queue",
             items_sent, results_seen, n_reused, ids_dropped);
    $display("%0d creates found no free id, %0d operations hit an absent id",
             n_full, n_absent);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d entity %0d live %0d", $time,
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[48:40]);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[7:0] !== want.ent) begin
            $display("%0t: entity_out expected %0d actual %0d", $time, want.ent,
                     m_axis_tdata[7:0]);
            mismatches++;
          end
          if (m_axis_tdata[39:8] !== want.sig) begin
            $display("%0t: signature_out expected %h actual %h", $time, want.sig,
                     m_axis_tdata[39:8]);
            mismatches++;
          end
          if (m_axis_tdata[48:40] !== want.live) begin
            $display("%0t: live_count expected %0d actual %0d", $time, want.live,
                     m_axis_tdata[48:40]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/sst_pkg.sv
rtl/sst_free_fifo.sv
rtl/sst_engine.sv
rtl/sparse_set_id_table_top.sv
bench/sparse_set_id_table_top_tb.sv
